### hdl/mco_pkg.sv
// Package: shared widths for the matrix-chain order block.
`timescale 1ns / 1ps
package mco_pkg;

  // Input dimension width
  localparam int unsigned DIM_W    = 16;
  // Width of the index fields in a result beat
  localparam int unsigned IDX_FW   = 4;
  // Cost width: sum of up to ten 48-bit products
  localparam int unsigned COST_W   = 52;
  // Partial product widths
  localparam int unsigned PROD1_W  = 2 * DIM_W;
  localparam int unsigned PROD_W   = 3 * DIM_W;
  // Packed result tdata width (start, end, split, cost)
  localparam int unsigned OUT_DATA_W = 3 * IDX_FW + COST_W;

endpackage

### hdl/mco_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module mco_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/matrix_chain_order_top.sv
// Top level: matrix-chain order solver with a shared multiply/add/compare unit.
//
//  channel | dir | handshake            | content
//  in_     | in  | in_tvalid/in_tready  | tdata[15:0] dimension, tlast is_last
//  out_    | out | out_tvalid/out_tready| tdata start,end,split,cost; tuser ovf; tlast
//
//  A dimension beat is taken while in_tready is high; the beat with tlast starts the solve.
//  A sub-chain runs S_SEG and S_SEG2, then for each split candidate S_JRD,
//  S_MUL1, S_MUL2 and S_CMP, then S_WR, which waits while the previous result
//  beat is still held. Each split candidate goes through table read, first
//  multiply, second multiply, add and compare.
//  in_tready is low from the last dimension until the final result beat leaves.
//  rst_n is synchronous, active low; no clearing pass is needed.
`timescale 1ns / 1ps
module matrix_chain_order_top
  import mco_pkg::*;
#(
  parameter int unsigned MAX_MATRICES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DIM_W-1:0]      in_tdata,   // [15:0] dimension
  input  logic                  in_tlast,   // is_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [3:0] range_start, [7:4] range_end,
                                            // [11:8] best_split, [63:12] min_cost
  output logic                  out_tuser,  // overflowed
  output logic                  out_tlast   // last_result
);

  localparam int unsigned DIM_SLOTS = MAX_MATRICES + 1;
  localparam int unsigned IDXW      = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int unsigned DIMW      = $clog2(DIM_SLOTS);
  localparam int unsigned CNTW      = $clog2(DIM_SLOTS + 1);
  localparam int unsigned TAB_AW    = 2 * IDXW;
  localparam int unsigned TAB_W     = COST_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SEG, S_SEG2, S_JRD, S_MUL1, S_MUL2, S_CMP, S_WR
  } state_t;

  state_t state_r;
  logic   in_busy_r;   // high while a run is in flight

  // chain capture
  logic [CNTW-1:0] dims_cnt_r;
  logic            ovf_r;
  logic            run_ovf_r;
  logic [DIMW-1:0] m_r;

  // loop indexes
  logic [DIMW-1:0] len_r;
  logic [IDXW-1:0] s_r, e_r, j_r;

  // shared unit datapath
  logic [DIM_W-1:0]   ds_r, de_r;
  logic [PROD1_W-1:0] p1_r;
  logic [PROD_W-1:0]  prod_r;
  logic [COST_W-1:0]  sum_r, best_r, cand_cost;
  logic [IDXW-1:0]    bsplit_r;
  logic               take_cand;

  // output register
  logic              out_valid_r, out_last_r, out_ovf_r;
  logic [IDX_FW-1:0] out_start_r, out_end_r, out_split_r;
  logic [COST_W-1:0] out_cost_r;

  // memories
  logic              dims_we;
  logic [DIMW-1:0]   dims_raddr_a, dims_raddr_b;
  logic [DIM_W-1:0]  dims_rdata_a, dims_rdata_b;
  logic              tab_we;
  logic [TAB_W-1:0]  tab_wdata, tab_rdata_a, tab_rdata_b;
  logic [TAB_AW-1:0] tab_raddr_a, tab_raddr_b;

  logic            in_beat, out_beat, has_room;
  logic [CNTW-1:0] cnt_after;
  logic [DIMW:0]   next_end;

  assign in_beat   = in_tvalid && in_tready;
  assign out_beat  = out_valid_r && out_tready;
  assign has_room  = (dims_cnt_r < CNTW'(DIM_SLOTS));
  assign cnt_after = has_room ? dims_cnt_r + CNTW'(1) : dims_cnt_r;
  // s + len: the end index of the next sub-chain at this length
  assign next_end  = (DIMW + 1)'(s_r) + (DIMW + 1)'(len_r);

  assign in_tready = !in_busy_r;

  // dimension store: port a walks s then j+1, port b holds e+1
  assign dims_we      = in_beat && has_room;
  assign dims_raddr_a = (state_r == S_JRD) ? DIMW'(j_r + IDXW'(1)) : DIMW'(s_r);
  assign dims_raddr_b = DIMW'(e_r) + DIMW'(1);

  mco_ram #(
    .WIDTH (DIM_W),
    .DEPTH (2 ** DIMW)
  ) u_dims_ram (
    .clk     (clk),
    .we      (dims_we),
    .waddr   (dims_cnt_r[DIMW-1:0]),
    .wdata   (in_tdata),
    .raddr_a (dims_raddr_a),
    .raddr_b (dims_raddr_b),
    .rdata_a (dims_rdata_a),
    .rdata_b (dims_rdata_b)
  );

  // cost table, addressed {start, end}; the split goes straight to the output
  assign tab_we      = (state_r == S_WR);
  assign tab_wdata   = best_r;
  assign tab_raddr_a = {s_r, j_r};
  assign tab_raddr_b = {j_r + IDXW'(1), e_r};

  mco_ram #(
    .WIDTH (TAB_W),
    .DEPTH (2 ** TAB_AW)
  ) u_tab_ram (
    .clk     (clk),
    .we      (tab_we),
    .waddr   ({s_r, e_r}),
    .wdata   (tab_wdata),
    .raddr_a (tab_raddr_a),
    .raddr_b (tab_raddr_b),
    .rdata_a (tab_rdata_a),
    .rdata_b (tab_rdata_b)
  );

  // candidate cost and compare; first split always taken
  assign cand_cost = sum_r + COST_W'(prod_r);
  assign take_cand = (j_r == s_r) || (cand_cost < best_r);

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_busy_r   <= 1'b0;
      dims_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_beat) begin
            out_valid_r <= 1'b0;
            in_busy_r   <= 1'b0;
          end
          if (in_beat) begin
            if (!in_tlast) begin
              dims_cnt_r <= cnt_after;
              if (!has_room) begin
                ovf_r <= 1'b1;
              end
            end else begin
              dims_cnt_r <= '0;
              ovf_r      <= 1'b0;
              run_ovf_r  <= ovf_r || !has_room;
              m_r        <= DIMW'(cnt_after - CNTW'(1));
              if (cnt_after == CNTW'(2)) begin
                // single matrix: one zero-cost result
                in_busy_r   <= 1'b1;
                out_valid_r <= 1'b1;
                out_start_r <= '0;
                out_end_r   <= '0;
                out_split_r <= '0;
                out_cost_r  <= '0;
                out_ovf_r   <= ovf_r || !has_room;
                out_last_r  <= 1'b1;
              end else if (cnt_after > CNTW'(2)) begin
                in_busy_r <= 1'b1;
                len_r     <= DIMW'(2);
                s_r       <= '0;
                e_r       <= IDXW'(1);
                state_r   <= S_SEG;
              end
            end
          end
        end
        S_SEG: begin
          j_r     <= s_r;
          state_r <= S_SEG2;
        end
        S_SEG2: begin
          ds_r    <= dims_rdata_a;
          de_r    <= dims_rdata_b;
          state_r <= S_JRD;
        end
        S_JRD: begin
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          // diagonal entries are zero cost and never stored
          p1_r  <= PROD1_W'(ds_r) * PROD1_W'(dims_rdata_a);
          sum_r <= ((j_r == s_r) ? '0 : tab_rdata_a[COST_W-1:0])
                 + ((j_r + IDXW'(1) == e_r) ? '0 : tab_rdata_b[COST_W-1:0]);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= PROD_W'(p1_r) * PROD_W'(de_r);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (take_cand) begin
            best_r   <= cand_cost;
            bsplit_r <= j_r;
          end
          if (j_r + IDXW'(1) == e_r) begin
            state_r <= S_WR;
          end else begin
            j_r     <= j_r + IDXW'(1);
            state_r <= S_JRD;
          end
        end
        S_WR: begin
          // wait for the previous beat to leave, then load this one
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_start_r <= IDX_FW'(s_r);
            out_end_r   <= IDX_FW'(e_r);
            out_split_r <= IDX_FW'(bsplit_r);
            out_cost_r  <= best_r;
            out_ovf_r   <= run_ovf_r;
            out_last_r  <= (len_r == m_r);
            if (len_r == m_r) begin
              state_r <= S_IDLE;
            end else if (next_end < (DIMW + 1)'(m_r)) begin
              s_r     <= s_r + IDXW'(1);
              e_r     <= e_r + IDXW'(1);
              state_r <= S_SEG;
            end else begin
              len_r   <= len_r + DIMW'(1);
              s_r     <= '0;
              e_r     <= IDXW'(len_r);
              state_r <= S_SEG;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // beat taken while the solver runs on
      if (state_r != S_IDLE && state_r != S_WR && out_beat) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cost_r, out_split_r, out_end_r, out_start_r};
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

  // no new chain is taken while a result beat is pending
  a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready with a result pending");

  // capture count never exceeds the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dims_cnt_r <= CNTW'(DIM_SLOTS))
    else $error("dimension count beyond capacity");

  // a sub-chain never ends before it starts
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] <= out_tdata[7:4]))
    else $error("result range reversed");

  // the split candidate stays inside the sub-chain
  a_split_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (j_r >= s_r && j_r < e_r))
    else $error("split index out of range");

  // the final result beat frees the input side
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("input not ready after final result");

endmodule
